[sv/vmsz_pkg.sv]
// Package for the voxel statistics engine: opcodes, widths and the store request struct.
// No dependencies.
`default_nettype none
package vmsz_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_FINAL = 2'd2,
    OP_SCORE = 2'd3
  } op_e;

  localparam int unsigned SUM_W = 32;
  localparam int unsigned SQ_W  = 56;
  localparam int unsigned VAL_W = 24;
  localparam int unsigned VOX_W = 16;
  localparam int unsigned CFG_W = 9;

  typedef struct packed {
    logic              start;
    logic [VOX_W-1:0]  index;
    logic              wr;
    logic [SUM_W-1:0]  sum_wdata;
    logic [SQ_W-1:0]   sq_wdata;
  } mem_req_t;
endpackage
`default_nettype wire

[sv/vmsz_store.sv]
// Voxel state store: two synchronous single-port memories with registered read data.
// Depends on vmsz_pkg. Cleared by a sweep after reset.
`default_nettype none
module vmsz_store #(
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vmsz_pkg::mem_req_t            req_i,
  output logic                               clr_busy_o,
  output logic [vmsz_pkg::SUM_W-1:0]         sum_rdata_o,
  output logic [vmsz_pkg::SQ_W-1:0]          sq_rdata_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [vmsz_pkg::SUM_W-1:0] sum_mem [DEPTH];
  logic [vmsz_pkg::SQ_W-1:0]  sq_mem  [DEPTH];
  logic [AW:0]                clr_q;
  logic [AW-1:0]              addr;

  assign clr_busy_o = (clr_q < (AW+1)'(DEPTH));
  assign addr = clr_busy_o ? clr_q[AW-1:0] : req_i.index[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      sum_mem[addr] <= '0;
      sq_mem[addr]  <= '0;
    end else if (req_i.wr) begin
      sum_mem[addr] <= req_i.sum_wdata;
      sq_mem[addr]  <= req_i.sq_wdata;
    end
    sum_rdata_o <= sum_mem[addr];
    sq_rdata_o  <= sq_mem[addr];
  end
endmodule
`default_nettype wire

[sv/vmsz_core.sv]
// Sequencer: read-modify-write of one voxel, with serial divide and square root.
// Depends on vmsz_pkg; drives vmsz_store requests.
`default_nettype none
module vmsz_core #(
  parameter int unsigned VOXEL_COUNT = 65536,
  parameter int unsigned MAX_MAPS    = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [vmsz_pkg::VOX_W-1:0]    voxel_index_i,
  input  wire logic signed [vmsz_pkg::VAL_W-1:0] sample_value_i,
  input  wire logic [vmsz_pkg::CFG_W-1:0]    n_maps_i,
  input  wire logic                          clr_busy_i,
  input  wire logic [vmsz_pkg::SUM_W-1:0]    sum_rdata_i,
  input  wire logic [vmsz_pkg::SQ_W-1:0]     sq_rdata_i,
  output vmsz_pkg::mem_req_t                 req_o,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [vmsz_pkg::VOX_W-1:0]         voxel_echo_o,
  output logic [vmsz_pkg::VAL_W-1:0]         zscore_o,
  output logic signed [vmsz_pkg::VAL_W-1:0]  mean_value_o,
  output logic [vmsz_pkg::VAL_W-1:0]         deviation_o,
  output logic                               saturated_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_DIVM, S_MSQ, S_SQ, S_VAR, S_SQRT, S_FIN,
    S_ZDIV, S_DONE
  } state_e;

  localparam int unsigned NW = (MAX_MAPS > 1) ? $clog2(MAX_MAPS + 1) : 1;
  localparam logic [vmsz_pkg::CFG_W+NW-1:0] MAXN = (vmsz_pkg::CFG_W+NW)'(MAX_MAPS);

  state_e state_q;
  logic [1:0]  op_q;
  logic [vmsz_pkg::VOX_W-1:0] idx_q;
  logic signed [vmsz_pkg::VAL_W-1:0] smp_q;
  logic [vmsz_pkg::CFG_W+NW-1:0] n_q;
  logic [63:0] rem_q, quo_q, dvd_q, dvs_q;
  logic [6:0]  cnt_q;
  logic        neg_q;
  logic signed [vmsz_pkg::VAL_W-1:0] mean_q;
  logic [vmsz_pkg::VAL_W-1:0] dev_q, z_q;
  logic [55:0] msq_q;
  logic [47:0] msqm_q;
  logic        sat_q, wr_q;
  logic [vmsz_pkg::SUM_W-1:0] sumw_q;
  logic [vmsz_pkg::SQ_W-1:0]  sqw_q;

  logic in_range;
  logic signed [33:0] acc_s;
  logic [56:0] acc_q;
  logic signed [47:0] sq_prod;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [64:0] sq_trial;
  logic signed [32:0] diff;

  assign in_range = ({8'd0, idx_q} < 24'(VOXEL_COUNT)) || (VOXEL_COUNT > 65535);
  assign busy_o = (state_q != S_IDLE) || clr_busy_i;
  assign sq_prod = smp_q * smp_q;
  assign acc_s = 34'(signed'(sum_rdata_i)) + 34'(smp_q);
  assign acc_q = {1'b0, sq_rdata_i} + 57'(unsigned'(sq_prod));
  assign rem_sh = {rem_q[62:0], dvd_q[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};
  assign sq_trial = {1'b0, rem_q} - {1'b0, (quo_q | dvs_q)};
  assign diff = 33'(smp_q) - 33'(mean_q);

  assign req_o.start     = start_i && !busy_o;
  assign req_o.index     = (state_q == S_IDLE) ? voxel_index_i : idx_q;
  assign req_o.wr        = wr_q;
  assign req_o.sum_wdata = sumw_q;
  assign req_o.sq_wdata  = sqw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      wr_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_o.start) begin
            op_q  <= opcode_i;
            idx_q <= voxel_index_i;
            smp_q <= sample_value_i;
            n_q   <= (n_maps_i == '0) ? (vmsz_pkg::CFG_W+NW)'(1) :
                     (({{NW{1'b0}}, n_maps_i} > MAXN) ? MAXN :
                      {{NW{1'b0}}, n_maps_i});
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_EVAL;
        S_EVAL: begin
          mean_q <= '0; dev_q <= '0; z_q <= '0; sat_q <= 1'b0;
          if (!in_range) begin
            state_q <= S_DONE;
          end else begin
            case (op_q)
              vmsz_pkg::OP_CLEAR: begin
                sumw_q <= '0; sqw_q <= '0; wr_q <= 1'b1; state_q <= S_DONE;
              end
              vmsz_pkg::OP_ACCUM: begin
                sumw_q <= (acc_s > 34'sh07FFFFFFF) ? 32'h7FFFFFFF :
                          (acc_s < -34'sh080000000) ? 32'h80000000 : acc_s[31:0];
                sqw_q  <= acc_q[56] ? {56{1'b1}} : acc_q[55:0];
                sat_q  <= acc_q[56] || (acc_s > 34'sh07FFFFFFF) ||
                          (acc_s < -34'sh080000000);
                wr_q   <= 1'b1;
                state_q <= S_DONE;
              end
              vmsz_pkg::OP_FINAL: begin
                neg_q <= sum_rdata_i[31];
                dvd_q <= {32'd0, sum_rdata_i[31] ? (~sum_rdata_i + 1'b1) : sum_rdata_i};
                msq_q <= sq_rdata_i;
                dvs_q <= 64'(n_q);
                rem_q <= '0; quo_q <= '0; cnt_q <= 7'd64;
                state_q <= S_DIVM;
              end
              default: begin
                if ($signed(sum_rdata_i) > 32'sd8388607) begin
                  mean_q <= 24'sd8388607; sat_q <= 1'b1;
                end else if ($signed(sum_rdata_i) < -32'sd8388608) begin
                  mean_q <= -24'sd8388608; sat_q <= 1'b1;
                end else begin
                  mean_q <= sum_rdata_i[23:0];
                end
                if (sq_rdata_i[55:24] != '0) begin
                  dev_q <= '1; sat_q <= 1'b1;
                end else begin
                  dev_q <= sq_rdata_i[23:0];
                end
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_DIVM, S_MSQ, S_ZDIV: begin
          if (cnt_q != '0) begin
            dvd_q <= {dvd_q[62:0], 1'b0};
            if (!trial[64]) begin
              rem_q <= trial[63:0]; quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh; quo_q <= {quo_q[62:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
          end else if (state_q == S_DIVM) begin
            if (!neg_q && quo_q > 64'd8388607) begin
              mean_q <= 24'sd8388607; sat_q <= 1'b1;
            end else if (neg_q && quo_q > 64'd8388608) begin
              mean_q <= -24'sd8388608; sat_q <= 1'b1;
            end else begin
              mean_q <= neg_q ? (~quo_q[23:0] + 1'b1) : quo_q[23:0];
            end
            dvd_q <= {8'd0, msq_q};
            rem_q <= '0; quo_q <= '0; cnt_q <= 7'd64;
            state_q <= S_MSQ;
          end else if (state_q == S_MSQ) begin
            msq_q <= quo_q[55:0];
            state_q <= S_SQ;
          end else begin
            if (quo_q > 64'hFFFFFF) begin
              z_q <= '1; sat_q <= 1'b1;
            end else begin
              z_q <= quo_q[23:0];
            end
            state_q <= S_DONE;
          end
        end
        S_SQ: begin
          msqm_q <= unsigned'(48'(mean_q) * 48'(mean_q));
          state_q <= S_VAR;
        end
        S_VAR: begin
          rem_q <= (msq_q > {8'd0, msqm_q}) ? 64'(msq_q - {8'd0, msqm_q}) : '0;
          quo_q <= '0;
          dvs_q <= 64'h4000000000000000;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (dvs_q != '0) begin
            if (!sq_trial[64]) begin
              rem_q <= sq_trial[63:0];
              quo_q <= (quo_q >> 1) | dvs_q;
            end else begin
              quo_q <= quo_q >> 1;
            end
            dvs_q <= dvs_q >> 2;
          end else begin
            if (quo_q > 64'hFFFFFF) begin
              dev_q <= '1; sat_q <= 1'b1;
            end else begin
              dev_q <= quo_q[23:0];
              if (quo_q == '0) sat_q <= 1'b1;
            end
            sumw_q <= 32'(mean_q);
            sqw_q  <= (quo_q > 64'hFFFFFF) ? 56'hFFFFFF : 56'(quo_q[23:0]);
            wr_q   <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_FIN: begin
          if (dev_q == '0) begin
            sat_q <= 1'b1;
            z_q <= (diff > 0) ? '1 : '0;
            state_q <= S_DONE;
          end else if (diff > 0) begin
            dvd_q <= {15'd0, diff[32:0], 16'd0};
            dvs_q <= 64'(dev_q);
            rem_q <= '0; quo_q <= '0; cnt_q <= 7'd64;
            state_q <= S_ZDIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          done_o       <= 1'b1;
          voxel_echo_o <= idx_q;
          zscore_o     <= z_q;
          mean_value_o <= mean_q;
          deviation_o  <= dev_q;
          saturated_o  <= sat_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than a beat");
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q |-> busy_o) else $error("write while idle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_DONE)) else $error("stray result");
`endif
endmodule
`default_nettype wire

[sv/voxel_mean_std_zscore_top.sv]
// Top level of the per-voxel mean / deviation / z-score engine.
// Depends on vmsz_pkg, vmsz_store, vmsz_core.
//
// channel | ports                                   | handshake
// input   | opcode_i voxel_index_i sample_value_i   | start && !busy
// result  | voxel_echo_o zscore_o mean_value_o ...  | done_o, one beat
// config  | cfg_we_i cfg_data_i                     | cfg_we_i
//
// Accept to next accept: clear and accumulate read, evaluate and write back; finalize
// adds two serial divides and a serial square root; score adds a serial z divide only
// when the sample exceeds the mean and the deviation is nonzero. After reset a sweep
// clears the store, one entry per cycle, with busy high. Results cannot be stalled.
`default_nettype none
module voxel_mean_std_zscore_top #(
  parameter int unsigned VOXEL_COUNT = 65536,
  parameter int unsigned MAX_MAPS    = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [vmsz_pkg::VOX_W-1:0]    voxel_index_i,
  input  wire logic signed [vmsz_pkg::VAL_W-1:0] sample_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [vmsz_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic [vmsz_pkg::VOX_W-1:0]         voxel_echo_o,
  output logic [vmsz_pkg::VAL_W-1:0]         zscore_o,
  output logic signed [vmsz_pkg::VAL_W-1:0]  mean_value_o,
  output logic [vmsz_pkg::VAL_W-1:0]         deviation_o,
  output logic                               saturated_o
);
  localparam int unsigned DEPTH = (VOXEL_COUNT > 65536) ? 65536 : VOXEL_COUNT;

  logic [vmsz_pkg::CFG_W-1:0] n_maps_q;
  vmsz_pkg::mem_req_t req;
  logic clr_busy;
  logic [vmsz_pkg::SUM_W-1:0] sum_rdata;
  logic [vmsz_pkg::SQ_W-1:0]  sq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_maps_q <= vmsz_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      n_maps_q <= cfg_data_i;
    end
  end

  vmsz_store #(.DEPTH(DEPTH)) u_store (
    .clk_i, .rst_ni, .req_i(req), .clr_busy_o(clr_busy),
    .sum_rdata_o(sum_rdata), .sq_rdata_o(sq_rdata)
  );

  vmsz_core #(.VOXEL_COUNT(VOXEL_COUNT), .MAX_MAPS(MAX_MAPS)) u_core (
    .clk_i, .rst_ni, .start_i(start), .opcode_i, .voxel_index_i, .sample_value_i,
    .n_maps_i(n_maps_q), .clr_busy_i(clr_busy), .sum_rdata_i(sum_rdata),
    .sq_rdata_i(sq_rdata), .req_o(req), .busy_o(busy), .done_o,
    .voxel_echo_o, .zscore_o, .mean_value_o, .deviation_o, .saturated_o
  );
endmodule
`default_nettype wire
